/* hdl/qtg_pkg.sv */
`timescale 1ns / 1ps

package qtg_pkg;

	// Coefficient count: terms coeff_0 .. coeff_(COEFF_COUNT-1) are evaluated.
	localparam int COEFF_COUNT    = 6;
	localparam int NUM_COEFF_REGS = 6;
	localparam int COEFF_IDX_W    = 3;

	localparam int TIME_W = 32;   // unsigned Q8.24
	localparam int ACC_W  = 64;   // signed Q32.32
	localparam int POS_W  = 48;   // signed Q16.32
	localparam int HALF_W = 32;   // multiplier operand width

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;

	localparam int S_TDATA_W = 32;
	localparam int M_TDATA_W = 88;
	localparam int M_PAD_W   = M_TDATA_W - POS_W - TIME_W - 1;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_COEFF0   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COEFF5   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_DURATION = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_START_X  = 3'd7;

	// Horner walk indexes
	localparam logic [COEFF_IDX_W-1:0] TOP_IDX   = COEFF_IDX_W'(COEFF_COUNT - 1);
	localparam logic [COEFF_IDX_W-1:0] FIRST_IDX = COEFF_IDX_W'(COEFF_COUNT - 2);

	// Reset values
	localparam logic [ACC_W-1:0] COEFF0_RST = 64'sd0;
	localparam logic [ACC_W-1:0] COEFF1_RST = 64'sd0;
	localparam logic [ACC_W-1:0] COEFF2_RST = 64'sd0;
	localparam logic [ACC_W-1:0] COEFF3_RST = 64'sd429496729600;
	localparam logic [ACC_W-1:0] COEFF4_RST = -64'sd6442450944000;
	localparam logic [ACC_W-1:0] COEFF5_RST = 64'sd25769803776000;
	localparam logic [TIME_W-1:0] DURATION_RST = 32'd1677722;

	// Half an LSB of the Q8.24 time scaling, for round-to-nearest
	localparam logic [ACC_W-1:0] ROUND_HALF = 64'h0000_0000_0080_0000;

	localparam logic [ACC_W-1:0] S64_MAX = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic [ACC_W-1:0] S64_MIN = {1'b1, {(ACC_W-1){1'b0}}};
	localparam logic [POS_W-1:0] S48_MAX = {1'b0, {(POS_W-1){1'b1}}};
	localparam logic [POS_W-1:0] S48_MIN = {1'b1, {(POS_W-1){1'b0}}};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ABS,
		ST_MLO,
		ST_MHI,
		ST_RND,
		ST_ADD,
		ST_FIN,
		ST_OUT
	} state_t;

endpackage

/* hdl/quintic_trajectory_generator_core.sv */
`timescale 1ns / 1ps

// Quintic trajectory generator. Each input beat is one control tick carrying
// its period (unsigned Q8.24 s); the period is added to a saturating elapsed
// time. While elapsed < duration the polynomial sum(coeff_i * t^i) is evaluated
// at the new elapsed time by Horner's method (signed Q32.32, rounded and
// saturated at every step) and kept as the offset; afterwards the last offset
// is held. Every tick yields one output beat: start_x + offset (saturated
// Q16.32), the elapsed time and an in-motion flag. All multiplication runs on
// one shared 32x32 multiplier under a small sequencer. A moving tick passes
// the accept state, then per Horner step the magnitude, low partial product,
// high partial product, round/saturate and accumulate states, then one state
// to clamp the offset and one to load the output; a tick that is not moving
// goes from the accept state straight to the output load. s_tready is high
// only while the sequencer is idle; a finished beat waits in the output
// register, so the next tick is taken while it waits. Coefficients, duration
// and start_x are written through the cfg port (always ready) while no tick
// is in flight; the user must keep to this, the block does not enforce it.
module quintic_trajectory_generator_core (
	input  logic                              clk,
	input  logic                              arst_n,
	// tick input; tdata: [31:0] tick_period
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [qtg_pkg::S_TDATA_W-1:0]     s_tdata,
	// result output; tdata: [47:0] commanded_x, [79:48] elapsed_now,
	// [80] in_motion, [87:81] zero
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [qtg_pkg::M_TDATA_W-1:0]     m_tdata,
	// configuration writes
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [qtg_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [qtg_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import qtg_pkg::*;

	state_t state_q, state_d;

	// configuration
	logic [ACC_W-1:0]  coeff_q [NUM_COEFF_REGS];
	logic [TIME_W-1:0] duration_q;
	logic [POS_W-1:0]  start_x_q;

	// block state
	logic [TIME_W-1:0] elapsed_q;
	logic [POS_W-1:0]  held_offset_q;
	logic              moving_q;

	// Horner datapath
	logic [COEFF_IDX_W-1:0] idx_q;
	logic [ACC_W-1:0]       acc_q;
	logic [ACC_W-1:0]       mag_q;
	logic                   neg_q;
	logic [ACC_W-1:0]       lo_q;
	logic [ACC_W-1:0]       mid_q;
	logic [ACC_W-1:0]       prod_q;

	// output register
	logic              out_valid_q;
	logic [POS_W-1:0]  cmd_q;
	logic [TIME_W-1:0] elapsed_out_q;
	logic              in_motion_q;

	logic              s_accept;
	logic              out_load;
	logic [TIME_W:0]   tick_sum;
	logic [TIME_W-1:0] elapsed_next;
	logic              moving_next;

	logic [HALF_W-1:0]   mul_a;
	logic [2*HALF_W-1:0] mul_p;

	logic [ACC_W-1:0] rnd_mag;
	logic             rnd_ovf;
	logic [ACC_W-1:0] rnd_val;

	logic [ACC_W:0]   add_sum;
	logic [ACC_W-1:0] add_val;

	logic [POS_W-1:0] acc_sat48;
	logic [POS_W:0]   cmd_sum;
	logic [POS_W-1:0] cmd_val;

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == ST_IDLE);
	assign s_accept  = s_tvalid && s_tready;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{M_PAD_W{1'b0}}, in_motion_q, elapsed_out_q, cmd_q};

	// elapsed time, saturating at all ones
	assign tick_sum     = {1'b0, elapsed_q} + {1'b0, s_tdata[TIME_W-1:0]};
	assign elapsed_next = tick_sum[TIME_W] ? {TIME_W{1'b1}} : tick_sum[TIME_W-1:0];
	assign moving_next  = elapsed_next < duration_q;

	// shared multiplier: low word in ST_MLO, high word in ST_MHI
	assign mul_a = (state_q == ST_MHI) ? mag_q[ACC_W-1:HALF_W] : mag_q[HALF_W-1:0];
	assign mul_p = {{HALF_W{1'b0}}, mul_a} * {{HALF_W{1'b0}}, elapsed_q};

	// rescale by 2^-24 and saturate to signed 64 bits
	assign rnd_ovf = |mid_q[ACC_W-1:56];
	assign rnd_mag = {mid_q[55:0], lo_q[31:24]};
	always_comb begin
		if (!neg_q) begin
			rnd_val = (rnd_ovf || rnd_mag[ACC_W-1]) ? S64_MAX : rnd_mag;
		end else begin
			rnd_val = (rnd_ovf || rnd_mag[ACC_W-1]) ? S64_MIN : (~rnd_mag + 1'b1);
		end
	end

	// saturating accumulate of the current coefficient
	assign add_sum = {prod_q[ACC_W-1], prod_q} + {coeff_q[idx_q][ACC_W-1], coeff_q[idx_q]};
	always_comb begin
		if (add_sum[ACC_W] != add_sum[ACC_W-1]) begin
			add_val = add_sum[ACC_W] ? S64_MIN : S64_MAX;
		end else begin
			add_val = add_sum[ACC_W-1:0];
		end
	end

	// Q32.32 -> Q16.32 with saturation
	always_comb begin
		if (acc_q[ACC_W-1:POS_W-1] == {(ACC_W-POS_W+1){acc_q[ACC_W-1]}}) begin
			acc_sat48 = acc_q[POS_W-1:0];
		end else begin
			acc_sat48 = acc_q[ACC_W-1] ? S48_MIN : S48_MAX;
		end
	end

	// start_x + offset, saturated
	assign cmd_sum = {start_x_q[POS_W-1], start_x_q} + {held_offset_q[POS_W-1], held_offset_q};
	always_comb begin
		if (cmd_sum[POS_W] != cmd_sum[POS_W-1]) begin
			cmd_val = cmd_sum[POS_W] ? S48_MIN : S48_MAX;
		end else begin
			cmd_val = cmd_sum[POS_W-1:0];
		end
	end

	assign out_load = (state_q == ST_OUT) && (!out_valid_q || m_tready);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_accept) begin
					state_d = moving_next ? ST_ABS : ST_OUT;
				end
			end
			ST_ABS: state_d = ST_MLO;
			ST_MLO: state_d = ST_MHI;
			ST_MHI: state_d = ST_RND;
			ST_RND: state_d = ST_ADD;
			ST_ADD: state_d = (idx_q == '0) ? ST_FIN : ST_ABS;
			ST_FIN: state_d = ST_OUT;
			ST_OUT: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coeff_q[0] <= COEFF0_RST;
			coeff_q[1] <= COEFF1_RST;
			coeff_q[2] <= COEFF2_RST;
			coeff_q[3] <= COEFF3_RST;
			coeff_q[4] <= COEFF4_RST;
			coeff_q[5] <= COEFF5_RST;
			duration_q <= DURATION_RST;
			start_x_q  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index) inside
				[REG_COEFF0:REG_COEFF5]: coeff_q[cfg_index] <= cfg_data;
				REG_DURATION:            duration_q <= cfg_data[TIME_W-1:0];
				REG_START_X:             start_x_q  <= cfg_data[POS_W-1:0];
				default:                 ;
			endcase
		end
	end

	// block state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elapsed_q     <= '0;
			held_offset_q <= '0;
			moving_q      <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (s_accept) begin
				elapsed_q <= elapsed_next;
				moving_q  <= moving_next;
			end
			if (state_q == ST_FIN) begin
				held_offset_q <= acc_sat48;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			cmd_q         <= cmd_val;
			elapsed_out_q <= elapsed_q;
			in_motion_q   <= moving_q;
		end
	end

	// Horner datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				acc_q <= coeff_q[TOP_IDX];
				idx_q <= FIRST_IDX;
			end
			ST_ABS: begin
				neg_q <= acc_q[ACC_W-1];
				mag_q <= acc_q[ACC_W-1] ? (~acc_q + 1'b1) : acc_q;
			end
			ST_MLO: lo_q   <= mul_p + ROUND_HALF;
			ST_MHI: mid_q  <= mul_p + {{HALF_W{1'b0}}, lo_q[ACC_W-1:HALF_W]};
			ST_RND: prod_q <= rnd_val;
			ST_ADD: begin
				acc_q <= add_val;
				idx_q <= idx_q - 1'b1;
			end
			default: ;
		endcase
	end

`ifndef SYNTH
	// offset only moves at the end of an evaluation
	a_held_only_fin: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_FIN) |=> $stable(held_offset_q))
		else $error("held offset changed outside ST_FIN");

	// elapsed time never runs backwards
	a_elapsed_mono: assert property (@(posedge clk) disable iff (!arst_n)
		s_accept |=> (elapsed_q >= $past(elapsed_q)))
		else $error("elapsed time decreased");

	// a finished tick waits until the output register frees up
	a_out_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT && out_valid_q && !m_tready) |=> (state_q == ST_OUT))
		else $error("result left ST_OUT while output stalled");

	// evaluation only runs for a moving tick
	a_eval_moving: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ABS) |-> moving_q)
		else $error("polynomial evaluated while not moving");
`endif

endmodule
